FILE: design/htw_pkg.sv
// Shared types, codes and defaults for the hierarchical timer wheel.
`default_nettype none
package htw_pkg;

  localparam int NUM_TIMERS_DEF = 64;
  localparam int SLOT_BITS_DEF  = 6;
  localparam int NUM_WHEELS_DEF = 4;

  localparam int LINK_W = 7;
  localparam logic [LINK_W-1:0] LINK_NONE = 7'd127;

  localparam logic [1:0] CMD_SET    = 2'd0;
  localparam logic [1:0] CMD_CANCEL = 2'd1;
  localparam logic [1:0] CMD_ADV    = 2'd2;
  localparam logic [1:0] CMD_RSVD   = 2'd3;

  localparam logic [1:0] KIND_ACK  = 2'd0;
  localparam logic [1:0] KIND_EXP  = 2'd1;
  localparam logic [1:0] KIND_NONE = 2'd2;

  typedef enum logic [1:0] {OP_ACK, OP_SET, OP_CANCEL, OP_ADV} op_t;

  typedef struct packed {
    op_t         op;
    logic [5:0]  id;
    logic [31:0] delay;
    logic [63:0] new_time;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_out_t;

endpackage
`default_nettype wire

FILE: design/hierarchical_timer_wheel.sv
// Top level of the hierarchical timer wheel: command queue and engine.
// Advance examines the wheels in turn, sweeps their due slots and takes the timers there,
// reschedules each taken timer, then reports the expired timers.
// A two-entry queue takes new commands while the engine works; busy is high when full.
// Reset is synchronous: time, occupancy, timer places, the expired list and the queue clear.
`default_nettype none
module hierarchical_timer_wheel #(
  parameter int NUM_TIMERS = htw_pkg::NUM_TIMERS_DEF,
  parameter int SLOT_BITS  = htw_pkg::SLOT_BITS_DEF,
  parameter int NUM_WHEELS = htw_pkg::NUM_WHEELS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  command,
  input  wire logic [5:0]  timer_id,
  input  wire logic [31:0] delay,
  input  wire logic [63:0] new_time,
  output logic             valid,
  output logic [1:0]       result_kind,
  output logic [5:0]       expired_id,
  output logic             last
);

  htw_pkg::q_out_t q;
  logic            pop;

  htw_front #(
    .NUM_TIMERS(NUM_TIMERS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .command  (command),
    .timer_id (timer_id),
    .delay    (delay),
    .new_time (new_time),
    .q        (q),
    .pop      (pop)
  );

  htw_back #(
    .NUM_TIMERS (NUM_TIMERS),
    .SLOT_BITS  (SLOT_BITS),
    .NUM_WHEELS (NUM_WHEELS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q           (q),
    .pop         (pop),
    .valid       (valid),
    .result_kind (result_kind),
    .expired_id  (expired_id),
    .last        (last)
  );

endmodule
`default_nettype wire

FILE: design/htw_front.sv
// Command intake: classifies commands and holds them in a two-entry queue.
`default_nettype none
module htw_front #(
  parameter int NUM_TIMERS = htw_pkg::NUM_TIMERS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire logic [1:0]    command,
  input  wire logic [5:0]    timer_id,
  input  wire logic [31:0]   delay,
  input  wire logic [63:0]   new_time,
  output htw_pkg::q_out_t    q,
  input  wire logic          pop
);

  htw_pkg::cmd_t in_cmd;
  htw_pkg::cmd_t qmem [2];
  logic          wp;
  logic          rp;
  logic [1:0]    cnt;
  logic [1:0]    cnt_next;
  logic          push;
  logic          id_ok;

  assign id_ok = {1'b0, timer_id} < 7'(NUM_TIMERS);

  always_comb begin
    in_cmd.id       = timer_id;
    in_cmd.delay    = delay;
    in_cmd.new_time = new_time;
    case (command)
      htw_pkg::CMD_SET:    in_cmd.op = id_ok ? htw_pkg::OP_SET : htw_pkg::OP_ACK;
      htw_pkg::CMD_CANCEL: in_cmd.op = id_ok ? htw_pkg::OP_CANCEL : htw_pkg::OP_ACK;
      htw_pkg::CMD_ADV:    in_cmd.op = htw_pkg::OP_ADV;
      default:             in_cmd.op = htw_pkg::OP_ACK;
    endcase
  end

  assign busy     = (cnt == 2'd2);
  assign push     = start && !busy;
  assign cnt_next = cnt + 2'(push) - 2'(pop);
  assign q.valid  = (cnt != 2'd0);
  assign q.cmd    = qmem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) qmem[wp] <= in_cmd;
  end

endmodule
`default_nettype wire

FILE: design/htw_back.sv
// Command engine: slot lists, wheel sweep, rescheduling and expiry drain.
`default_nettype none
module htw_back #(
  parameter int NUM_TIMERS = htw_pkg::NUM_TIMERS_DEF,
  parameter int SLOT_BITS  = htw_pkg::SLOT_BITS_DEF,
  parameter int NUM_WHEELS = htw_pkg::NUM_WHEELS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire htw_pkg::q_out_t q,
  output logic             pop,
  output logic             valid,
  output logic [1:0]       result_kind,
  output logic [5:0]       expired_id,
  output logic             last
);

  localparam int WLEN   = 1 << SLOT_BITS;
  localparam int NSLOTS = NUM_WHEELS * WLEN;
  localparam int ID_W   = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int WH_W   = (NUM_WHEELS > 1) ? $clog2(NUM_WHEELS) : 1;
  localparam int IDX_W  = WH_W + SLOT_BITS;
  localparam int PL_W   = $clog2(NSLOTS + 2);
  localparam int SPAN_W = SLOT_BITS * NUM_WHEELS;
  localparam int CNT_W  = $clog2(NUM_TIMERS + 1);
  localparam int LW     = htw_pkg::LINK_W;
  localparam logic [PL_W-1:0] PL_IDLE = PL_W'(0);
  localparam logic [PL_W-1:0] PL_EXP  = PL_W'(1);

  typedef enum logic [4:0] {
    S_IDLE, S_RM0, S_RM1, S_SCH0, S_SCH1, S_PUSH, S_PUSH2, S_ADV0, S_W0, S_W1,
    S_SCAN, S_WLK, S_RS0, S_RS1, S_RS2, S_DR0, S_DR1
  } state_t;

  function automatic logic [WLEN-1:0] rotl(input logic [WLEN-1:0] v,
                                           input logic [SLOT_BITS-1:0] c);
    logic [2*WLEN-1:0] d;
    d = {v, v} << c;
    return d[2*WLEN-1:WLEN];
  endfunction

  function automatic logic [WLEN-1:0] rotr(input logic [WLEN-1:0] v,
                                           input logic [SLOT_BITS-1:0] c);
    logic [2*WLEN-1:0] d;
    d = {v, v} >> c;
    return d[WLEN-1:0];
  endfunction

  state_t              state;
  htw_pkg::op_t        op;
  logic [ID_W-1:0]     op_id;
  logic [63:0]         op_exp;
  logic [63:0]         now;
  logic [63:0]         cur_time;
  logic [63:0]         elapsed;
  logic [WH_W-1:0]     wheel;
  logic [WLEN-1:0]     due;
  logic [WLEN-1:0]     t1;
  logic [WLEN-1:0]     a1;
  logic                big;
  logic [SLOT_BITS-1:0] e_r;
  logic [SPAN_W-1:0]   rem;
  logic                tgt_exp;
  logic [IDX_W-1:0]    tgt_idx;
  logic [LW-1:0]       push_t;
  logic                use_head;
  logic [CNT_W-1:0]    ntodo;
  logic [CNT_W-1:0]    ri;
  logic [ID_W-1:0]     dr_id;
  logic [LW-1:0]       exp_head;
  logic [LW-1:0]       exp_tail;
  logic [WLEN-1:0]     occ [NUM_WHEELS];
  logic [NUM_TIMERS-1:0] pvld;

  // Memories and their ports.
  logic [63:0]     exp_mem   [NUM_TIMERS];
  logic [LW-1:0]   next_mem  [NUM_TIMERS];
  logic [LW-1:0]   prev_mem  [NUM_TIMERS];
  logic [PL_W-1:0] place_mem [NUM_TIMERS];
  logic [LW-1:0]   head_mem  [NSLOTS];
  logic [LW-1:0]   tail_mem  [NSLOTS];
  logic [ID_W-1:0] todo_mem  [NUM_TIMERS];

  logic exp_we, next_we, prev_we, place_we, head_we, tail_we, todo_we;
  logic [ID_W-1:0]  exp_wa, exp_ra, next_wa, next_ra, prev_wa, prev_ra;
  logic [ID_W-1:0]  place_wa, place_ra, todo_wa, todo_ra;
  logic [IDX_W-1:0] head_wa, head_ra, tail_wa, tail_ra;
  logic [63:0]      exp_wd, exp_rd;
  logic [LW-1:0]    next_wd, next_rd, prev_wd, prev_rd;
  logic [LW-1:0]    head_wd, head_rd, tail_wd, tail_rd;
  logic [PL_W-1:0]  place_wd, place_rd;
  logic [ID_W-1:0]  todo_wd, todo_rd;

  // Combinational helpers.
  logic [PL_W-1:0]      pl_eff;
  logic [IDX_W-1:0]     rm_idx;
  logic [LW-1:0]        id7;
  logic [WH_W-1:0]      wsel;
  logic [63:0]          exp_sh;
  logic [SLOT_BITS-1:0] sch_slot;
  logic [IDX_W-1:0]     sch_idx;
  logic [LW-1:0]        pt;
  logic                 tgt_occ;
  logic [WLEN-1:0]      m;
  logic [SLOT_BITS-1:0] scan_slot;
  logic [IDX_W-1:0]     scan_idx;
  logic [LW-1:0]        cl;
  logic [63:0]          el_sh;
  logic [63:0]          diff;
  logic [63:0]          span;
  logic [SLOT_BITS-1:0] os;
  logic [SLOT_BITS-1:0] ns;
  logic [WLEN-1:0]      fill;
  logic [WLEN-1:0]      one_ns;

  assign pl_eff = pvld[op_id] ? place_rd : PL_IDLE;
  assign rm_idx = IDX_W'(pl_eff - PL_W'(2));
  assign id7    = LW'(op_id);
  // An empty slot has no tail, whatever its tail entry holds.
  assign tgt_occ = occ[tgt_idx[IDX_W-1:SLOT_BITS]][tgt_idx[SLOT_BITS-1:0]];
  assign pt     = tgt_exp ? exp_tail : (tgt_occ ? tail_rd : htw_pkg::LINK_NONE);
  assign cl     = use_head ? head_rd : next_rd;
  assign m      = due & occ[wheel];
  assign diff   = op_exp - cur_time;
  assign el_sh  = elapsed >> (wheel * SLOT_BITS);
  assign span   = 64'(WLEN) << (wheel * SLOT_BITS);
  assign os     = SLOT_BITS'(cur_time >> (wheel * SLOT_BITS));
  assign ns     = SLOT_BITS'(now >> (wheel * SLOT_BITS));
  assign fill   = ~({WLEN{1'b1}} << el_sh[SLOT_BITS-1:0]);
  assign one_ns = {{(WLEN-1){1'b0}}, 1'b1} << ns;
  assign pop    = (state == S_IDLE) && q.valid;

  // The wheel is the highest one whose part of the remaining time is non-zero.
  always_comb begin
    wsel = '0;
    for (int w = 1; w < NUM_WHEELS; w++) begin
      if ((rem >> (w * SLOT_BITS)) != '0) wsel = WH_W'(w);
    end
    exp_sh   = op_exp >> (wsel * SLOT_BITS);
    sch_slot = exp_sh[SLOT_BITS-1:0] - SLOT_BITS'(wsel != '0);
    sch_idx  = {wsel, sch_slot};
  end

  always_comb begin
    scan_slot = '0;
    for (int i = WLEN - 1; i >= 0; i--) begin
      if (m[i]) scan_slot = SLOT_BITS'(i);
    end
    scan_idx = {wheel, scan_slot};
  end

  always_comb begin
    exp_we = 1'b0; next_we = 1'b0; prev_we = 1'b0; place_we = 1'b0;
    head_we = 1'b0; tail_we = 1'b0; todo_we = 1'b0;
    exp_wa = '0; exp_ra = '0; next_wa = '0; next_ra = '0; prev_wa = '0; prev_ra = '0;
    place_wa = '0; place_ra = '0; todo_wa = '0; todo_ra = '0;
    head_wa = '0; head_ra = '0; tail_wa = '0; tail_ra = '0;
    exp_wd = op_exp; next_wd = '0; prev_wd = '0; head_wd = '0; tail_wd = '0;
    place_wd = PL_IDLE; todo_wd = '0;
    case (state)
      S_RM0: begin
        next_ra  = op_id;
        prev_ra  = op_id;
        place_ra = op_id;
      end
      S_RM1: begin
        if (pl_eff != PL_IDLE) begin
          place_we = 1'b1;
          place_wa = op_id;
          if (prev_rd != htw_pkg::LINK_NONE) begin
            next_we = 1'b1;
            next_wa = prev_rd[ID_W-1:0];
            next_wd = next_rd;
          end else if (pl_eff != PL_EXP) begin
            head_we = 1'b1;
            head_wa = rm_idx;
            head_wd = next_rd;
          end
          if (next_rd != htw_pkg::LINK_NONE) begin
            prev_we = 1'b1;
            prev_wa = next_rd[ID_W-1:0];
            prev_wd = prev_rd;
          end else if (pl_eff != PL_EXP) begin
            tail_we = 1'b1;
            tail_wa = rm_idx;
            tail_wd = prev_rd;
          end
        end
      end
      S_SCH0: begin
        exp_we = 1'b1;
        exp_wa = op_id;
      end
      S_SCH1: begin
        tail_ra = sch_idx;
      end
      S_PUSH: begin
        next_we  = 1'b1;
        next_wa  = op_id;
        next_wd  = htw_pkg::LINK_NONE;
        prev_we  = 1'b1;
        prev_wa  = op_id;
        prev_wd  = pt;
        place_we = 1'b1;
        place_wa = op_id;
        place_wd = tgt_exp ? PL_EXP : PL_W'(tgt_idx) + PL_W'(2);
        if (!tgt_exp) begin
          tail_we = 1'b1;
          tail_wa = tgt_idx;
          tail_wd = id7;
          if (pt == htw_pkg::LINK_NONE) begin
            head_we = 1'b1;
            head_wa = tgt_idx;
            head_wd = id7;
          end
        end
      end
      S_PUSH2: begin
        if (push_t != htw_pkg::LINK_NONE) begin
          next_we = 1'b1;
          next_wa = push_t[ID_W-1:0];
          next_wd = id7;
        end
      end
      S_SCAN: begin
        if (m != '0) begin
          head_ra = scan_idx;
          head_we = 1'b1;
          head_wa = scan_idx;
          head_wd = htw_pkg::LINK_NONE;
          tail_we = 1'b1;
          tail_wa = scan_idx;
          tail_wd = htw_pkg::LINK_NONE;
        end
      end
      S_WLK: begin
        if (cl != htw_pkg::LINK_NONE) begin
          todo_we  = 1'b1;
          todo_wa  = ntodo[ID_W-1:0];
          todo_wd  = cl[ID_W-1:0];
          place_we = 1'b1;
          place_wa = cl[ID_W-1:0];
          next_ra  = cl[ID_W-1:0];
        end
      end
      S_RS0: todo_ra = ri[ID_W-1:0];
      S_RS1: exp_ra = todo_rd;
      S_DR0: next_ra = exp_head[ID_W-1:0];
      S_DR1: begin
        place_we = 1'b1;
        place_wa = dr_id;
        if (next_rd != htw_pkg::LINK_NONE) begin
          prev_we = 1'b1;
          prev_wa = next_rd[ID_W-1:0];
          prev_wd = htw_pkg::LINK_NONE;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (exp_we) exp_mem[exp_wa] <= exp_wd;
    exp_rd <= exp_mem[exp_ra];
  end

  always_ff @(posedge clk) begin
    if (next_we) next_mem[next_wa] <= next_wd;
    next_rd <= next_mem[next_ra];
  end

  always_ff @(posedge clk) begin
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    prev_rd <= prev_mem[prev_ra];
  end

  always_ff @(posedge clk) begin
    if (place_we) place_mem[place_wa] <= place_wd;
    place_rd <= place_mem[place_ra];
  end

  always_ff @(posedge clk) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    head_rd <= head_mem[head_ra];
  end

  always_ff @(posedge clk) begin
    if (tail_we) tail_mem[tail_wa] <= tail_wd;
    tail_rd <= tail_mem[tail_ra];
  end

  always_ff @(posedge clk) begin
    if (todo_we) todo_mem[todo_wa] <= todo_wd;
    todo_rd <= todo_mem[todo_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      cur_time    <= '0;
      exp_head    <= htw_pkg::LINK_NONE;
      exp_tail    <= htw_pkg::LINK_NONE;
      pvld        <= '0;
      valid       <= 1'b0;
      result_kind <= htw_pkg::KIND_ACK;
      expired_id  <= '0;
      last        <= 1'b0;
      for (int w = 0; w < NUM_WHEELS; w++) occ[w] <= '0;
    end else begin
      valid <= 1'b0;
      if (place_we) pvld[place_wa] <= 1'b1;
      case (state)
        S_IDLE: begin
          if (q.valid) begin
            op     <= q.cmd.op;
            op_id  <= q.cmd.id[ID_W-1:0];
            op_exp <= cur_time + 64'(q.cmd.delay);
            now    <= q.cmd.new_time;
            case (q.cmd.op)
              htw_pkg::OP_SET, htw_pkg::OP_CANCEL: state <= S_RM0;
              htw_pkg::OP_ADV: state <= S_ADV0;
              default: begin
                valid       <= 1'b1;
                result_kind <= htw_pkg::KIND_ACK;
                expired_id  <= '0;
                last        <= 1'b1;
              end
            endcase
          end
        end
        S_RM0: state <= S_RM1;
        S_RM1: begin
          if (pl_eff == PL_EXP) begin
            if (prev_rd == htw_pkg::LINK_NONE) exp_head <= next_rd;
            if (next_rd == htw_pkg::LINK_NONE) exp_tail <= prev_rd;
          end else if (pl_eff != PL_IDLE && prev_rd == htw_pkg::LINK_NONE &&
                       next_rd == htw_pkg::LINK_NONE) begin
            occ[rm_idx[IDX_W-1:SLOT_BITS]][rm_idx[SLOT_BITS-1:0]] <= 1'b0;
          end
          if (op == htw_pkg::OP_SET) begin
            state <= S_SCH0;
          end else begin
            state       <= S_IDLE;
            valid       <= 1'b1;
            result_kind <= htw_pkg::KIND_ACK;
            expired_id  <= '0;
            last        <= 1'b1;
          end
        end
        S_SCH0: begin
          rem     <= ((diff >> SPAN_W) != '0) ? '1 : diff[SPAN_W-1:0];
          tgt_exp <= !(op_exp > cur_time);
          state   <= S_SCH1;
        end
        S_SCH1: begin
          tgt_idx <= sch_idx;
          state   <= S_PUSH;
        end
        S_PUSH: begin
          push_t <= pt;
          if (tgt_exp) begin
            exp_tail <= id7;
            if (pt == htw_pkg::LINK_NONE) exp_head <= id7;
          end else begin
            occ[tgt_idx[IDX_W-1:SLOT_BITS]][tgt_idx[SLOT_BITS-1:0]] <= 1'b1;
          end
          state <= S_PUSH2;
        end
        S_PUSH2: begin
          if (op == htw_pkg::OP_ADV) begin
            ri    <= ri + CNT_W'(1);
            state <= S_RS0;
          end else begin
            state       <= S_IDLE;
            valid       <= 1'b1;
            result_kind <= htw_pkg::KIND_ACK;
            expired_id  <= '0;
            last        <= 1'b1;
          end
        end
        S_ADV0: begin
          elapsed <= now - cur_time;
          wheel   <= '0;
          ntodo   <= '0;
          state   <= S_W0;
        end
        S_W0: begin
          big   <= (el_sh >> SLOT_BITS) != '0;
          e_r   <= el_sh[SLOT_BITS-1:0];
          a1    <= rotl(fill, os) | one_ns;
          t1    <= rotl(fill, ns);
          state <= S_W1;
        end
        S_W1: begin
          due   <= big ? '1 : (a1 | rotr(t1, e_r));
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (m != '0) begin
            occ[wheel][scan_slot] <= 1'b0;
            use_head <= 1'b1;
            state    <= S_WLK;
          end else if (!due[0] || wheel == WH_W'(NUM_WHEELS - 1)) begin
            // Sweep over: time moves on before the taken timers are placed again.
            cur_time <= now;
            ri       <= '0;
            state    <= S_RS0;
          end else begin
            if (elapsed < span) elapsed <= span;
            wheel <= wheel + WH_W'(1);
            state <= S_W0;
          end
        end
        S_WLK: begin
          use_head <= 1'b0;
          if (cl == htw_pkg::LINK_NONE) begin
            state <= S_SCAN;
          end else begin
            ntodo <= ntodo + CNT_W'(1);
          end
        end
        S_RS0: state <= (ri == ntodo) ? S_DR0 : S_RS1;
        S_RS1: begin
          op_id <= todo_rd;
          state <= S_RS2;
        end
        S_RS2: begin
          op_exp <= exp_rd;
          state  <= S_SCH0;
        end
        S_DR0: begin
          if (exp_head == htw_pkg::LINK_NONE) begin
            state       <= S_IDLE;
            valid       <= 1'b1;
            result_kind <= htw_pkg::KIND_NONE;
            expired_id  <= '0;
            last        <= 1'b1;
          end else begin
            dr_id <= exp_head[ID_W-1:0];
            state <= S_DR1;
          end
        end
        S_DR1: begin
          exp_head    <= next_rd;
          valid       <= 1'b1;
          result_kind <= htw_pkg::KIND_EXP;
          expired_id  <= 6'(dr_id);
          last        <= (next_rd == htw_pkg::LINK_NONE);
          if (next_rd == htw_pkg::LINK_NONE) begin
            exp_tail <= htw_pkg::LINK_NONE;
            state    <= S_IDLE;
          end else begin
            state <= S_DR0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_ack_last: assert property (@(posedge clk) disable iff (rst)
    valid && result_kind != htw_pkg::KIND_EXP |-> last)
    else $error("acknowledge or empty result without last");

  a_exp_list: assert property (@(posedge clk) disable iff (rst)
    (exp_head == htw_pkg::LINK_NONE) == (exp_tail == htw_pkg::LINK_NONE))
    else $error("expired list head and tail disagree on emptiness");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    valid |-> (last == (state == S_IDLE)))
    else $error("engine state does not match last flag of transfer");

  a_reset: assert property (@(posedge clk) rst |=> !valid && state == S_IDLE)
    else $error("engine not quiet after reset");
`endif

endmodule
`default_nettype wire
